>>> rtl/apl_pkg.sv
// Package for the audio peak level meter: field widths, channel count,
// the dB threshold table and the level to dB conversion function.
// No dependencies.
package apl_pkg;

	// Field widths and store geometry.
	localparam int LEVEL_W    = 16;
	localparam int DB_W       = 7;
	localparam int CHANNELS   = 2;
	localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Averaging and decay shifts: avg by 15/16, slow peak by 63/64, fast peak by 7/8.
	localparam int AVG_SHIFT  = 4;
	localparam int SLOW_SHIFT = 6;
	localparam int FAST_SHIFT = 3;

	// dB scale runs from 0 down to minus DB_STEPS.
	localparam int DB_STEPS = 40;
	localparam int DB_IDX_W = $clog2(DB_STEPS + 1);

	// Threshold per dB step; entry 0 is full scale and never compared.
	localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLDS [0:DB_STEPS] = '{
		16'h7fff, 16'h7213, 16'h65ab, 16'h5a9d, 16'h50c2, 16'h47fa, 16'h4026, 16'h392c,
		16'h32f4, 16'h2d6a, 16'h2879, 16'h2412, 16'h2026, 16'h1ca7, 16'h1989, 16'h16c2,
		16'h1449, 16'h1214, 16'h101d, 16'h0e5c, 16'h0ccc, 16'h0b68, 16'h0a2a, 16'h090f,
		16'h0813, 16'h0732, 16'h066a, 16'h05b7, 16'h0518, 16'h048a, 16'h040c, 16'h039b,
		16'h0337, 16'h02dd, 16'h028d, 16'h0246, 16'h0207, 16'h01ce, 16'h019c, 16'h016f,
		16'h0147
	};

	// The dB value is minus the highest step whose threshold lies above the level.
	function automatic logic signed [DB_W-1:0] level_to_db(input logic [LEVEL_W-1:0] level);
		logic [DB_IDX_W-1:0] step;
		logic [DB_W-1:0]     neg;
		step = '0;
		for (int i = 1; i <= DB_STEPS; i++) begin
			if (LEVEL_THRESHOLDS[i] > level) begin
				step = DB_IDX_W'(i);
			end
		end
		neg = DB_W'(0) - DB_W'(step);
		return signed'(neg);
	endfunction

endpackage

>>> rtl/audio_peak_level_meter.sv
// Top level of the audio peak level meter: input register, per-channel
// average and peak stores, update logic and result register.
// Depends on apl_pkg.

// Usage
// The sample channel carries one word per audio sample: a channel tag and a
// signed 16-bit sample, handed over with sample_valid and sample_ready. The
// result channel returns one word per sample: the channel, the magnitude,
// the updated average, both decayed peaks and both peaks in dB from -40 to 0,
// handed over with result_valid and result_ready.
// The input register takes the sample; its word moves on into the result
// register when that register is free. One sample is taken in every cycle
// while the receiver takes every result: the input register feeds a single
// pass of adders, compares and the dB table, which writes the per-channel
// stores and the result register at the same edge, so a following sample of
// the same channel always sees the updated state. Reset clears the average
// and peak stores of every channel and empties both registers. When the
// receiver stalls, the result register holds its word and the input register
// holds one more; sample_ready then falls until the result is taken.
module audio_peak_level_meter
	import apl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic                   channel,
	input  logic signed [15:0]     sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   channel_out,
	output logic [LEVEL_W-1:0]     magnitude,
	output logic [LEVEL_W-1:0]     average,
	output logic [LEVEL_W-1:0]     slow_peak,
	output logic [LEVEL_W-1:0]     fast_peak,
	output logic signed [DB_W-1:0] slow_peak_db,
	output logic signed [DB_W-1:0] fast_peak_db
);

	localparam int AVG_SUM_W  = LEVEL_W + AVG_SHIFT;
	localparam int SLOW_SUM_W = LEVEL_W + SLOW_SHIFT;
	localparam int FAST_SUM_W = LEVEL_W + FAST_SHIFT;

	logic                   valid_s1;
	logic                   channel_s1;
	logic signed [15:0]     sample_s1;
	logic                   res_valid_q;
	logic                   channel_q;
	logic [LEVEL_W-1:0]     mag_q;
	logic [LEVEL_W-1:0]     avg_out_q;
	logic [LEVEL_W-1:0]     slow_out_q;
	logic [LEVEL_W-1:0]     fast_out_q;
	logic signed [DB_W-1:0] slow_db_q;
	logic signed [DB_W-1:0] fast_db_q;

	logic [LEVEL_W-1:0] avg_store_q  [CHANNELS];
	logic [LEVEL_W-1:0] slow_store_q [CHANNELS];
	logic [LEVEL_W-1:0] fast_store_q [CHANNELS];

	logic                   advance;
	logic [CHAN_IDX_W-1:0]  idx;
	logic [LEVEL_W-1:0]     mag;
	logic [AVG_SUM_W-1:0]   avg_sum;
	logic [LEVEL_W-1:0]     avg_new;
	logic [LEVEL_W-1:0]     slow_raised;
	logic [LEVEL_W-1:0]     fast_raised;
	logic [SLOW_SUM_W-1:0]  slow_sum;
	logic [FAST_SUM_W-1:0]  fast_sum;
	logic [LEVEL_W-1:0]     slow_new;
	logic [LEVEL_W-1:0]     fast_new;

	// The word in the input register moves on whenever the result register is free.
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
	end

	// Store index; with a single channel every tag maps to entry zero.
	assign idx = (CHANNELS > 1) ? CHAN_IDX_W'(channel_s1) : '0;

	// Magnitude; the most negative sample gives full scale, which still fits.
	assign mag = sample_s1[15] ? LEVEL_W'(~sample_s1 + 16'sd1) : LEVEL_W'(sample_s1);

	// Running average: (15 * avg + mag) / 16.
	always_comb begin
		avg_sum = AVG_SUM_W'({avg_store_q[idx], {AVG_SHIFT{1'b0}}})
			- AVG_SUM_W'(avg_store_q[idx]) + AVG_SUM_W'(mag);
		avg_new = avg_sum[AVG_SUM_W-1:AVG_SHIFT];
	end

	// Peaks are raised to the magnitude, then decay towards the new average.
	always_comb begin
		slow_raised = (mag > slow_store_q[idx]) ? mag : slow_store_q[idx];
		fast_raised = (mag > fast_store_q[idx]) ? mag : fast_store_q[idx];
		slow_sum = SLOW_SUM_W'({slow_raised, {SLOW_SHIFT{1'b0}}})
			- SLOW_SUM_W'(slow_raised) + SLOW_SUM_W'(avg_new);
		fast_sum = FAST_SUM_W'({fast_raised, {FAST_SHIFT{1'b0}}})
			- FAST_SUM_W'(fast_raised) + FAST_SUM_W'(avg_new);
		slow_new = slow_sum[SLOW_SUM_W-1:SLOW_SHIFT];
		fast_new = fast_sum[FAST_SUM_W-1:FAST_SHIFT];
	end

	// Per-channel stores, written together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				avg_store_q[i]  <= '0;
				slow_store_q[i] <= '0;
				fast_store_q[i] <= '0;
			end
		end else if (advance) begin
			avg_store_q[idx]  <= avg_new;
			slow_store_q[idx] <= slow_new;
			fast_store_q[idx] <= fast_new;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			channel_q  <= channel_s1;
			mag_q      <= mag;
			avg_out_q  <= avg_new;
			slow_out_q <= slow_new;
			fast_out_q <= fast_new;
			slow_db_q  <= level_to_db(slow_new);
			fast_db_q  <= level_to_db(fast_new);
		end
	end

	assign result_valid = res_valid_q;
	assign channel_out  = channel_q;
	assign magnitude    = mag_q;
	assign average      = avg_out_q;
	assign slow_peak    = slow_out_q;
	assign fast_peak    = fast_out_q;
	assign slow_peak_db = slow_db_q;
	assign fast_peak_db = fast_db_q;

endmodule

>>> rtl/apl_checker.sv
// Port-level checks for the audio peak level meter, attached by bind.
// Depends on apl_pkg and the audio_peak_level_meter port list.
module apl_checker
	import apl_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic                   channel_out,
	input logic [LEVEL_W-1:0]     magnitude,
	input logic [LEVEL_W-1:0]     average,
	input logic [LEVEL_W-1:0]     slow_peak,
	input logic [LEVEL_W-1:0]     fast_peak,
	input logic signed [DB_W-1:0] slow_peak_db,
	input logic signed [DB_W-1:0] fast_peak_db
);

	localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << (LEVEL_W - 1);

	// A stalled result word stays on offer unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(channel_out)
			&& $stable(magnitude) && $stable(average) && $stable(slow_peak)
			&& $stable(fast_peak) && $stable(slow_peak_db) && $stable(fast_peak_db))
		else $error("result word changed while stalled");

	// Nothing is offered in the cycle after reset has been seen.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result offered straight after reset");

	// Levels never exceed full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> magnitude <= FULL_SCALE && average <= FULL_SCALE
			&& slow_peak <= FULL_SCALE && fast_peak <= FULL_SCALE)
		else $error("level above full scale");

	// The slow peak reads 0 dB exactly when it reaches the first step threshold.
	a_slow_db_top: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((slow_peak_db == '0) == (slow_peak >= LEVEL_THRESHOLDS[1])))
		else $error("slow peak dB disagrees with its level at the top of the scale");

	// Both dB readings stay on the scale.
	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> slow_peak_db <= 0 && slow_peak_db >= -DB_STEPS
			&& fast_peak_db <= 0 && fast_peak_db >= -DB_STEPS)
		else $error("dB reading off the scale");

endmodule

bind audio_peak_level_meter apl_checker u_apl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.channel_out  (channel_out),
	.magnitude    (magnitude),
	.average      (average),
	.slow_peak    (slow_peak),
	.fast_peak    (fast_peak),
	.slow_peak_db (slow_peak_db),
	.fast_peak_db (fast_peak_db)
);

>>> bench/audio_peak_level_meter_tb.sv
// Testbench for audio_peak_level_meter: drives tagged audio samples, predicts
// the per-channel level words in its own model and checks every result word.
// Depends on apl_pkg and the audio_peak_level_meter RTL.
`timescale 1ns / 1ps

module audio_peak_level_meter_tb;
	import apl_pkg::*;

	// One expected result word.
	typedef struct packed {
		logic                   ch;
		logic [LEVEL_W-1:0]     mag;
		logic [LEVEL_W-1:0]     avg;
		logic [LEVEL_W-1:0]     slow;
		logic [LEVEL_W-1:0]     fast;
		logic signed [DB_W-1:0] slow_db;
		logic signed [DB_W-1:0] fast_db;
	} level_word_t;

	// Level below which each dB step applies; step 0 is full scale and never used by level_db.
	localparam logic [15:0] DB_STEP_LEVEL [0:40] = '{
		16'h7fff, 16'h7213, 16'h65ab, 16'h5a9d, 16'h50c2, 16'h47fa, 16'h4026, 16'h392c,
		16'h32f4, 16'h2d6a, 16'h2879, 16'h2412, 16'h2026, 16'h1ca7, 16'h1989, 16'h16c2,
		16'h1449, 16'h1214, 16'h101d, 16'h0e5c, 16'h0ccc, 16'h0b68, 16'h0a2a, 16'h090f,
		16'h0813, 16'h0732, 16'h066a, 16'h05b7, 16'h0518, 16'h048a, 16'h040c, 16'h039b,
		16'h0337, 16'h02dd, 16'h028d, 16'h0246, 16'h0207, 16'h01ce, 16'h019c, 16'h016f,
		16'h0147
	};
	localparam int LOWEST_DB = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_ready;
	logic                   channel = 1'b0;
	logic signed [15:0]     sample = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic                   channel_out;
	logic [LEVEL_W-1:0]     magnitude;
	logic [LEVEL_W-1:0]     average;
	logic [LEVEL_W-1:0]     slow_peak;
	logic [LEVEL_W-1:0]     fast_peak;
	logic signed [DB_W-1:0] slow_peak_db;
	logic signed [DB_W-1:0] fast_peak_db;

	// Predicted meter state per channel.
	int avg_level [CHANNELS];
	int slow_hold [CHANNELS];
	int fast_hold [CHANNELS];

	level_word_t pending_levels [$];
	int          fault_count = 0;
	bit          src_idle_on = 1'b1;
	bit          snk_idle_on = 1'b1;
	int          stall_cycles = 0;
	int          snk_gap = 0;

	audio_peak_level_meter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.channel      (channel),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.channel_out  (channel_out),
		.magnitude    (magnitude),
		.average      (average),
		.slow_peak    (slow_peak),
		.fast_peak    (fast_peak),
		.slow_peak_db (slow_peak_db),
		.fast_peak_db (fast_peak_db)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Converts a level to dB: minus the lowest step still lying above it.
	function automatic logic signed [DB_W-1:0] level_db(input int lvl);
		for (int k = LOWEST_DB; k > 0; k--) begin
			if (int'(DB_STEP_LEVEL[k]) > lvl) begin
				return DB_W'(-k);
			end
		end
		return '0;
	endfunction

	// Updates the predicted state of one channel and forms the word it yields.
	task automatic update_meter(input logic ch, input logic [15:0] raw, output level_word_t w);
		int idx;
		int mag;
		int avg;
		int slow;
		int fast;
		idx  = int'(ch) % CHANNELS;
		mag  = raw[15] ? (65536 - int'(raw)) : int'(raw);
		avg  = (avg_level[idx] * 15 + mag) / 16;
		slow = (mag > slow_hold[idx]) ? mag : slow_hold[idx];
		fast = (mag > fast_hold[idx]) ? mag : fast_hold[idx];
		slow = (slow * 63 + avg) / 64;
		fast = (fast * 7 + avg) / 8;
		avg_level[idx] = avg;
		slow_hold[idx] = slow;
		fast_hold[idx] = fast;
		w.ch      = ch;
		w.mag     = LEVEL_W'(mag);
		w.avg     = LEVEL_W'(avg);
		w.slow    = LEVEL_W'(slow);
		w.fast    = LEVEL_W'(fast);
		w.slow_db = level_db(slow);
		w.fast_db = level_db(fast);
	endtask

	task automatic report_fault(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fault_count++;
	endtask

	// Offers one sample word, with an occasional idle burst first, and records
	// the prediction once it has been taken.
	task automatic send_word(input logic ch, input logic [15:0] s);
		level_word_t w;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		channel      <= ch;
		sample       <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		update_meter(ch, s, w);
		pending_levels.push_back(w);
	endtask

	// Picks a magnitude, favouring dB step boundaries and full scale.
	function automatic int pick_level();
		int lvl;
		case ($urandom_range(0, 5))
			0: lvl = int'(DB_STEP_LEVEL[$urandom_range(0, LOWEST_DB)]) + $urandom_range(0, 2) - 1;
			1: lvl = 32768;
			2: lvl = 32767;
			3: lvl = 0;
			4: lvl = $urandom_range(0, 1023);
			default: lvl = $urandom_range(0, 32768);
		endcase
		if (lvl < 0) lvl = 0;
		return lvl;
	endfunction

	// Turns a magnitude into a sample of random sign; full scale must be negative.
	function automatic logic [15:0] signed_sample(input int lvl);
		if (lvl == 32768 || (lvl != 0 && $urandom_range(0, 1) == 1)) begin
			return 16'(-lvl);
		end
		return 16'(lvl);
	endfunction

	// Receiver: a requested long stall, random idle bursts, otherwise ready.
	always @(posedge clk) begin
		if (stall_cycles > 0) begin
			result_ready <= 1'b0;
			stall_cycles = stall_cycles - 1;
		end else if (snk_gap > 0) begin
			result_ready <= 1'b0;
			snk_gap = snk_gap - 1;
		end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			snk_gap = $urandom_range(0, 3);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Compares each result word with the oldest prediction.
	always @(posedge clk) begin
		level_word_t w;
		if (arst_n && result_valid && result_ready) begin
			if (pending_levels.size() == 0) begin
				report_fault("result word with nothing expected");
			end else begin
				w = pending_levels.pop_front();
				if (channel_out !== w.ch)
					report_fault($sformatf("channel_out got %0d want %0d", channel_out, w.ch));
				if (magnitude !== w.mag)
					report_fault($sformatf("magnitude got %0d want %0d", magnitude, w.mag));
				if (average !== w.avg)
					report_fault($sformatf("average got %0d want %0d", average, w.avg));
				if (slow_peak !== w.slow)
					report_fault($sformatf("slow_peak got %0d want %0d", slow_peak, w.slow));
				if (fast_peak !== w.fast)
					report_fault($sformatf("fast_peak got %0d want %0d", fast_peak, w.fast));
				if (slow_peak_db !== w.slow_db)
					report_fault($sformatf("slow_peak_db got %0d want %0d",
						slow_peak_db, w.slow_db));
				if (fast_peak_db !== w.fast_db)
					report_fault($sformatf("fast_peak_db got %0d want %0d",
						fast_peak_db, w.fast_db));
			end
		end
	end

	// Extremes of the sample, both channels, dB step edges and decay to silence.
	task automatic test_directed();
		send_word(1'b0, 16'h0000);
		send_word(1'b1, 16'h0000);
		send_word(1'b0, 16'h8000);
		send_word(1'b0, 16'h8000);
		send_word(1'b0, 16'h8000);
		send_word(1'b1, 16'h7fff);
		send_word(1'b1, 16'hffff);
		send_word(1'b1, 16'h0001);
		send_word(1'b0, 16'h0147);
		send_word(1'b0, 16'h0146);
		send_word(1'b1, 16'h7213);
		send_word(1'b1, 16'h8ded);
		send_word(1'b0, 16'h5555);
		send_word(1'b1, 16'haaaa);
		repeat (8) send_word(1'b0, 16'h0000);
		send_word(1'b1, 16'h8001);
	endtask

	// Noise, sustained tones, decays and interleaved channels.
	task automatic test_random_traffic(input int n);
		int sent;
		int run;
		int lvl;
		logic ch;
		sent = 0;
		while (sent < n) begin
			ch = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: begin
					send_word(ch, 16'($urandom));
					sent++;
				end
				1: begin
					lvl = pick_level();
					run = $urandom_range(4, 40);
					repeat (run) begin
						send_word(ch, signed_sample(lvl));
						sent++;
					end
				end
				2: begin
					run = $urandom_range(4, 30);
					repeat (run) begin
						send_word(ch, signed_sample($urandom_range(0, 7)));
						sent++;
					end
				end
				default: begin
					run = $urandom_range(2, 16);
					repeat (run) begin
						send_word(1'($urandom_range(0, 1)), signed_sample(pick_level()));
						sent++;
					end
				end
			endcase
		end
	endtask

	// The receiver holds off while words keep coming, so the input stalls.
	task automatic test_backpressure();
		stall_cycles = 300;
		repeat (24) send_word(1'($urandom_range(0, 1)), 16'($urandom));
	endtask

	// Final stretch at full rate on both sides.
	task automatic test_full_rate();
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		test_random_traffic(500);
	endtask

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			avg_level[i] = 0;
			slow_hold[i] = 0;
			fast_hold[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(1300);
		test_backpressure();
		test_full_rate();
		sample_valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0) begin
			$display("PASS audio_peak_level_meter");
		end else begin
			$display("FAIL audio_peak_level_meter");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#5ms;
		$display("FAIL audio_peak_level_meter");
		$finish;
	end

endmodule

>>> filelist.f
rtl/apl_pkg.sv
rtl/audio_peak_level_meter.sv
rtl/apl_checker.sv
bench/audio_peak_level_meter_tb.sv
